>>> sv/sprite_frame_sequencer_defines.svh
// Assertion macros for the sprite frame sequencer.
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted.
`define SFS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define SFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/sfs_pkg.sv
// Shared types, constants and helpers for the sprite frame sequencer.
package sfs_pkg;

	localparam int MAX_FRAMES   = 64;
	localparam int NOTIFY_SLOTS = 4;

	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int CNT_W      = 7;
	localparam int NF_W       = 6;
	localparam int NOTIFY_W   = 4;
	localparam int ACC_W      = 32;
	localparam int FT_W       = 24;
	localparam int SCALE_W    = 16;
	localparam int ELAPSED_W  = 16;
	localparam int PROD_W     = ELAPSED_W + SCALE_W;
	localparam int FRAC_BITS  = 8;
	localparam int ADD_W      = PROD_W - FRAC_BITS;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_TIME     = 3'd0,
		REG_PLAY_SCALE     = 3'd1,
		REG_FRAME_COUNT    = 3'd2,
		REG_LOOP_ENABLE    = 3'd3,
		REG_REVERSE_ENABLE = 3'd4,
		REG_NOTIFY_FRAMES  = 3'd5,
		REG_NOTIFY_ENABLE  = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef struct packed {
		logic [ACC_W-1:0]    time_acc;
		logic [FRAME_W-1:0]  frame_pos;
		logic [NOTIFY_W-1:0] notify_fired;
	} seq_state_t;

	typedef struct packed {
		logic [FT_W-1:0]          frame_time;
		logic [CNT_W-1:0]         frame_count;
		logic                     loop_enable;
		logic                     reverse_enable;
		logic [NOTIFY_W*NF_W-1:0] notify_frames;
		logic [NOTIFY_W-1:0]      notify_enable;
	} seq_cfg_t;

	typedef struct packed {
		logic [FRAME_W-1:0]  frame_index;
		logic [NOTIFY_W-1:0] notify_hits;
		logic                anim_end;
	} seq_result_t;

	// Frame count as used by the stepper: zero reads as one, clamp at max.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] fc);
		logic [CNT_W-1:0] c;
		c = fc;
		if (c == '0)
			c = CNT_W'(1);
		if (c > MAX_CNT)
			c = MAX_CNT;
		return c;
	endfunction

endpackage

>>> sv/sfs_step.sv
// Per-tick update: time accumulate, frame step, end handling and notify matching.
module sfs_step
	import sfs_pkg::*;
(
	input  seq_cfg_t         cfg,
	input  seq_state_t       state,
	input  logic             restart,
	input  logic [ADD_W-1:0] scaled,
	output seq_state_t       next_state,
	output seq_result_t      result
);

	logic [ACC_W:0]     sum;
	logic [ACC_W-1:0]   acc_sat;
	logic [ACC_W-1:0]   ft_ext;
	logic               due;
	logic [ACC_W-1:0]   acc_tick;
	logic [CNT_W-1:0]   count;
	logic [CNT_W-1:0]   pos_ext;
	logic [CNT_W-1:0]   step_val;
	logic               step_neg;
	logic               ended;
	logic [NOTIFY_W-1:0] hits;
	logic [CNT_W-1:0]   end_pos;
	logic [FRAME_W-1:0] new_pos;

	assign sum     = {1'b0, state.time_acc} + (ACC_W+1)'(scaled);
	assign acc_sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
	assign ft_ext  = ACC_W'(cfg.frame_time);
	assign due     = (acc_sat >= ft_ext);
	assign acc_tick = due ? (acc_sat - ft_ext) : acc_sat;
	assign count   = eff_count(cfg.frame_count);
	assign pos_ext = CNT_W'(state.frame_pos);

	always_comb begin
		step_val = pos_ext;
		step_neg = 1'b0;
		ended    = 1'b0;
		if (due) begin
			if (cfg.reverse_enable) begin
				step_neg = (state.frame_pos == '0);
				step_val = pos_ext - CNT_W'(1);
				ended    = step_neg;
			end else begin
				step_val = pos_ext + CNT_W'(1);
				ended    = (step_val >= count);
			end
		end
	end

	// Match uses the stepped frame before the end fix-up; -1 never matches.
	always_comb begin
		hits = '0;
		for (int i = 0; i < NOTIFY_SLOTS; i++) begin
			if (cfg.notify_enable[i] && !state.notify_fired[i] && !step_neg &&
			    (CNT_W'(cfg.notify_frames[i*NF_W +: NF_W]) == step_val))
				hits[i] = 1'b1;
		end
	end

	always_comb begin
		if (cfg.loop_enable)
			end_pos = cfg.reverse_enable ? (count - CNT_W'(1)) : '0;
		else
			end_pos = cfg.reverse_enable ? '0 : (count - CNT_W'(1));
	end

	assign new_pos = ended ? end_pos[FRAME_W-1:0] : step_val[FRAME_W-1:0];

	always_comb begin
		if (restart) begin
			next_state = '0;
			result     = '0;
		end else begin
			next_state.time_acc     = acc_tick;
			next_state.frame_pos    = new_pos;
			next_state.notify_fired = (ended && cfg.loop_enable) ? '0
			                          : (state.notify_fired | hits);
			result.frame_index      = new_pos;
			result.notify_hits      = hits;
			result.anim_end         = ended;
		end
	end

endmodule

>>> sv/sprite_frame_sequencer.sv
// Sprite frame sequencer: steps one animation's frame index from time ticks.
//
// One transaction in, one transaction out, one per clock unless the sink stalls
// a held result. The first stage registers the Q16.8 product elapsed * play_scale
// (one 16x16 multiplier, low 8 bits dropped); the second stage adds it into the
// saturating 32-bit time accumulator, subtracts frame_time at most once, steps
// the frame up or down, handles the end of the sequence (wrap or hold, wrap
// re-arms the notify slots) and checks the notify slots, writing the result
// register and the sequencer state in the same edge. The state loop closes in
// that second stage, so back-to-back ticks see each other's updates. The
// output register is a single slot: in_stall rises only when it holds a result
// that the sink is stalling, and then the whole pipe holds. A restart
// transaction zeroes frame, time and fired flags and returns frame 0 with no
// hits and no end flag. Configuration is a plain write port (index = register
// number, data in the low bits) and must only be written while no transaction
// is in flight; registers come up at frame_time 1.0, play_scale 1.0, one frame,
// no loop, forward play, notify slots off.
module sprite_frame_sequencer
	import sfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Input transactions
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [ELAPSED_W-1:0]  elapsed,
	// Result transactions
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FRAME_W-1:0]    frame_index,
	output logic [NOTIFY_W-1:0]   notify_hits,
	output logic                  anim_end,
	// Configuration writes
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "sprite_frame_sequencer_defines.svh"

	// Configuration registers
	logic [FT_W-1:0]          frame_time_q;
	logic [SCALE_W-1:0]       play_scale_q;
	logic [CNT_W-1:0]         frame_count_q;
	logic                     loop_q;
	logic                     rev_q;
	logic [NOTIFY_W*NF_W-1:0] notify_frames_q;
	logic [NOTIFY_W-1:0]      notify_enable_q;

	// Stage 1: scaled time
	logic                     valid_s1;
	logic                     op_s1;
	logic [ADD_W-1:0]         scaled_s1;
	logic [PROD_W-1:0]        product;

	// Stage 2: state and result
	seq_state_t               state_q;
	seq_state_t               state_next;
	seq_result_t              res;
	seq_result_t              result_q;
	logic                     out_valid_q;
	seq_cfg_t                 cfg;
	logic                     advance;
	logic [CNT_W-1:0]         cnt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_time_q    <= FT_W'(256);
			play_scale_q    <= SCALE_W'(256);
			frame_count_q   <= CNT_W'(1);
			loop_q          <= 1'b0;
			rev_q           <= 1'b0;
			notify_frames_q <= '0;
			notify_enable_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_TIME:     frame_time_q    <= cfg_data[FT_W-1:0];
				REG_PLAY_SCALE:     play_scale_q    <= cfg_data[SCALE_W-1:0];
				REG_FRAME_COUNT:    frame_count_q   <= cfg_data[CNT_W-1:0];
				REG_LOOP_ENABLE:    loop_q          <= cfg_data[0];
				REG_REVERSE_ENABLE: rev_q           <= cfg_data[0];
				REG_NOTIFY_FRAMES:  notify_frames_q <= cfg_data[NOTIFY_W*NF_W-1:0];
				REG_NOTIFY_ENABLE:  notify_enable_q <= cfg_data[NOTIFY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.frame_time     = frame_time_q;
	assign cfg.frame_count    = frame_count_q;
	assign cfg.loop_enable    = loop_q;
	assign cfg.reverse_enable = rev_q;
	assign cfg.notify_frames  = notify_frames_q;
	assign cfg.notify_enable  = notify_enable_q;

	// Pipe moves unless a finished result sits stalled in the output register.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = !advance;

	assign product = PROD_W'(elapsed) * PROD_W'(play_scale_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			op_s1     <= operation;
			scaled_s1 <= product[PROD_W-1:FRAC_BITS];
		end
	end

	sfs_step u_step (
		.cfg        (cfg),
		.state      (state_q),
		.restart    (op_t'(op_s1) == OP_RESTART),
		.scaled     (scaled_s1),
		.next_state (state_next),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1)
				state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			result_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign frame_index = result_q.frame_index;
	assign notify_hits = result_q.notify_hits;
	assign anim_end    = result_q.anim_end;

	assign cnt_eff = eff_count(frame_count_q);

	// Only enabled slots ever report a hit.
	`SFS_ASSERT(a_hits_enabled, clk, arst_n, out_valid_q |-> ((result_q.notify_hits & ~notify_enable_q) == '0), "notify hit on a disabled slot")
	// Input side stalls only behind a held result.
	`SFS_ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> (out_valid_q && out_stall), "input stalled with output free")
	// Forward play without loop holds the last frame at the end.
	`SFS_ASSERT(a_hold_last, clk, arst_n, (out_valid_q && result_q.anim_end && !loop_q && !rev_q) |-> (result_q.frame_index == FRAME_W'(cnt_eff - CNT_W'(1))), "end without loop did not hold the last frame")
	// A hit on slot 0 implies its set frame equals the reported frame unless the sequence ended.
	`SFS_ASSERT(a_hit_frame, clk, arst_n, (out_valid_q && !result_q.anim_end && result_q.notify_hits[0]) |-> (CNT_W'(result_q.frame_index) == CNT_W'(notify_frames_q[NF_W-1:0])), "slot 0 hit on a different frame")

endmodule
